// File: src/mmrma_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mmrma_pkg: shared types and constants
// Widths, descriptor layout, status and register codes for the mask-match
// region memory access unit.
// ----------------------------------------------------------------------------
package mmrma_pkg;

  // store size; a power of two so the byte index wraps by truncation
  localparam int STORE_BYTES = 65536;
  localparam int STORE_AW    = $clog2(STORE_BYTES);
  localparam int MAX_REGIONS = 4;
  localparam int REGION_REGS = 4;
  localparam int SLOT_W      = $clog2(REGION_REGS);

  localparam int ADDR_W    = 20;
  localparam int LOCAL_W   = ADDR_W + 1;
  localparam int BASE_W    = 16;
  localparam int DESC_W    = 60;
  localparam int COUNT_W   = 3;
  localparam int CFG_IDX_W = 3;
  localparam int BC_W      = 4;
  localparam int DATA_W    = 64;
  localparam int LANE_W    = 3;

  localparam logic [BC_W-1:0] MAX_BYTES = 4'd8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_0     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_LAST  = 3'd4;

  // region type codes
  localparam logic [1:0] RT_DATA = 2'd0;
  localparam logic [1:0] RT_CODE = 2'd1;
  localparam logic [1:0] RT_BOTH = 2'd2;

  // result status codes
  localparam logic [1:0] ST_SERVED   = 2'd0;
  localparam logic [1:0] ST_NOREGION = 2'd1;
  localparam logic [1:0] ST_REFUSED  = 2'd2;
  localparam logic [1:0] ST_DEVICE   = 2'd3;

  typedef struct packed {
    logic [1:0]          status;
    logic [STORE_AW-1:0] local_idx;
  } dec_t;

  typedef struct packed {
    logic                en;
    logic                we;
    logic [STORE_AW-1:0] addr;
    logic [7:0]          wdata;
  } mem_req_t;

endpackage
`default_nettype wire

// File: src/mmrma_decode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mmrma_decode: region registers and parallel mask-match decoder
// Holds the region count and descriptors, and picks the first enabled region
// that matches the address and space of the transaction.
// ----------------------------------------------------------------------------
module mmrma_decode (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   cfg_we,
  input  wire [mmrma_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire [mmrma_pkg::DESC_W-1:0]           cfg_wdata,
  input  wire [mmrma_pkg::ADDR_W-1:0]           addr,
  input  wire                                   space,
  input  wire                                   is_write,
  output mmrma_pkg::dec_t                       dec
);
  import mmrma_pkg::*;

  logic [COUNT_W-1:0] count_r;
  logic [DESC_W-1:0]  desc_r [REGION_REGS];
  logic [REGION_REGS-1:0] hit;
  logic [CFG_IDX_W-1:0] cfg_off;

  assign cfg_off = cfg_index - CFG_REGION_0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      for (int r = 0; r < REGION_REGS; r++) begin
        desc_r[r] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == CFG_REGION_COUNT) begin
        count_r <= cfg_wdata[COUNT_W-1:0];
      end else if (cfg_index <= CFG_REGION_LAST) begin
        desc_r[cfg_off[SLOT_W-1:0]] <= cfg_wdata;
      end
    end
  end

  always_comb begin
    for (int r = 0; r < REGION_REGS; r++) begin
      hit[r] = (r < MAX_REGIONS) && (COUNT_W'(r) < count_r)
            && ((addr & desc_r[r][19:0]) == desc_r[r][39:20])
            && ((desc_r[r][41:40] == {1'b0, space}) || (desc_r[r][41:40] == RT_BOTH));
    end
  end

  always_comb begin
    logic             found;
    logic [DESC_W-1:0] d;
    logic [LOCAL_W-1:0] sum;
    found = 1'b0;
    d     = '0;
    for (int r = 0; r < REGION_REGS; r++) begin
      if (!found && hit[r]) begin
        found = 1'b1;
        d     = desc_r[r];
      end
    end
    sum = LOCAL_W'(addr & ~d[19:0]) + LOCAL_W'(d[59:44]);
    dec.local_idx = sum[STORE_AW-1:0];
    if (!found) begin
      dec.status = ST_NOREGION;
    end else if (is_write && !d[42]) begin
      dec.status = ST_REFUSED;
    end else if (d[43]) begin
      dec.status = ST_DEVICE;
    end else begin
      dec.status = ST_SERVED;
    end
  end

endmodule
`default_nettype wire

// File: src/mmrma_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mmrma_store: byte-wide store with clearing pass
// One byte read or written per cycle once busy is low, read data registered.
// After reset a sweep writes zero to every entry while busy is high.
// ----------------------------------------------------------------------------
module mmrma_store (
  input  wire                              clk,
  input  wire                              rst_n,
  input  mmrma_pkg::mem_req_t              req,
  output logic [7:0]                       rdata,
  output logic                             busy
);
  import mmrma_pkg::*;

  logic [7:0]          store_mem [STORE_BYTES];
  logic                clr_r, clr_nxt;
  logic [STORE_AW-1:0] clr_addr_r, clr_addr_nxt;

  always_comb begin
    clr_nxt      = clr_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_r) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
      if (&clr_addr_r) begin
        clr_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      clr_r      <= clr_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_r) begin
      store_mem[clr_addr_r] <= 8'h00;
    end else if (req.en && req.we) begin
      store_mem[req.addr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.en && !req.we) begin
      rdata <= store_mem[req.addr];
    end
  end

  assign busy = clr_r;

endmodule
`default_nettype wire

// File: src/mask_match_region_memory_access_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mask_match_region_memory_access_unit: region-decoded byte store access
// Input stream: one read or write of up to eight bytes at segment:offset.
// Result stream: read data (or write echo) and a status code.
// The cfg_ port writes the region count and four region descriptors; write it
// only while no transaction is in flight.
// Sequence: the access is decoded in S_MATCH; a served access then makes one
// store access per byte in S_ACCESS, waits in S_WAIT for the last read byte
// to return and loads the output register in S_DONE. A refused, unmatched,
// device or zero-byte access goes from S_MATCH straight to S_DONE. The next
// transaction is taken only back in S_IDLE, so no new access is taken while
// one is in progress; the bytes go through the single byte port of the store.
// Reset: state, valid and region registers clear; the store is swept to zero,
// one byte a cycle, over all 65536 entries; in_tready stays low meanwhile.
// Stall: the result waits in the output register; a new transaction is still
// taken, and its result is held back until the register frees up.
// ----------------------------------------------------------------------------
module mask_match_region_memory_access_unit (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_tvalid,
  output logic                                 in_tready,
  // segment[3:0], offset[19:4], byte_count[23:20], write_data[87:24]
  input  wire  [87:0]                          in_tdata,
  // command[0], space[1]
  input  wire  [1:0]                           in_tuser,
  output logic                                 out_tvalid,
  input  wire                                  out_tready,
  // read_data[63:0]
  output logic [63:0]                          out_tdata,
  // status[1:0]
  output logic [1:0]                           out_tuser,
  input  wire                                  cfg_we,
  input  wire  [mmrma_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [mmrma_pkg::DESC_W-1:0]         cfg_wdata
);
  import mmrma_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MATCH  = 3'd1;
  localparam logic [2:0] S_ACCESS = 3'd2;
  localparam logic [2:0] S_WAIT   = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0]          state_r, state_nxt;
  logic                cmd_r, cmd_nxt;
  logic                space_r, space_nxt;
  logic [ADDR_W-1:0]   addr_r, addr_nxt;
  logic [BC_W-1:0]     cnt_r, cnt_nxt;
  logic [DATA_W-1:0]   wdata_r, wdata_nxt;
  logic [1:0]          status_r, status_nxt;
  logic [STORE_AW-1:0] ptr_r, ptr_nxt;
  logic [BC_W-1:0]     idx_r, idx_nxt;
  logic                rd_pend_r, rd_pend_nxt;
  logic [LANE_W-1:0]   rd_lane_r, rd_lane_nxt;
  logic [DATA_W-1:0]   value_r, value_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]   out_data_r, out_data_nxt;
  logic [1:0]          out_status_r, out_status_nxt;

  logic                in_acc;
  logic [BC_W-1:0]     bc_in;
  dec_t                dec;
  mem_req_t            mem_req;
  logic [7:0]          mem_rdata;
  logic                mem_busy;

  mmrma_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .addr      (addr_r),
    .space     (space_r),
    .is_write  (cmd_r),
    .dec       (dec)
  );

  mmrma_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mem_req),
    .rdata (mem_rdata),
    .busy  (mem_busy)
  );

  assign in_tready = (state_r == S_IDLE) && !mem_busy;
  assign in_acc    = in_tvalid && in_tready;
  assign bc_in     = (in_tdata[23:20] > MAX_BYTES) ? MAX_BYTES : in_tdata[23:20];

  always_comb begin
    mem_req.en    = (state_r == S_ACCESS);
    mem_req.we    = cmd_r;
    mem_req.addr  = ptr_r;
    mem_req.wdata = wdata_r[idx_r[LANE_W-1:0]*8 +: 8];
  end

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    space_nxt      = space_r;
    addr_nxt       = addr_r;
    cnt_nxt        = cnt_r;
    wdata_nxt      = wdata_r;
    status_nxt     = status_r;
    ptr_nxt        = ptr_r;
    idx_nxt        = idx_r;
    value_nxt      = value_r;
    rd_pend_nxt    = (state_r == S_ACCESS) && !cmd_r;
    rd_lane_nxt    = idx_r[LANE_W-1:0];
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;

    if (rd_pend_r) begin
      value_nxt[rd_lane_r*8 +: 8] = mem_rdata;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt   = in_tuser[0];
          space_nxt = in_tuser[1];
          addr_nxt  = {in_tdata[3:0], in_tdata[19:4]};
          cnt_nxt   = bc_in;
          wdata_nxt = in_tdata[87:24];
          value_nxt = '0;
          idx_nxt   = '0;
          state_nxt = S_MATCH;
        end
      end
      S_MATCH: begin
        status_nxt = dec.status;
        ptr_nxt    = dec.local_idx;
        if ((dec.status != ST_SERVED) || (cnt_r == '0)) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_ACCESS;
        end
      end
      S_ACCESS: begin
        ptr_nxt = ptr_r + 1'b1;
        idx_nxt = idx_r + 1'b1;
        if (idx_r == cnt_r - 1'b1) begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          if (status_r != ST_SERVED) begin
            out_data_nxt = '0;
          end else if (cmd_r) begin
            out_data_nxt = wdata_r;
          end else begin
            out_data_nxt = value_r;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    space_r      <= space_nxt;
    addr_r       <= addr_nxt;
    cnt_r        <= cnt_nxt;
    wdata_r      <= wdata_nxt;
    status_r     <= status_nxt;
    ptr_r        <= ptr_nxt;
    idx_r        <= idx_nxt;
    rd_lane_r    <= rd_lane_nxt;
    value_r      <= value_nxt;
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

  a_no_access_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.en |-> !mem_busy)
    else $error("store accessed during clearing pass");

  a_accept_starts_match: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_MATCH))
    else $error("accepted transaction did not enter decode");

  a_access_needs_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACCESS) |-> ((cnt_r != '0) && (status_r == ST_SERVED)))
    else $error("store access without a served region or bytes");

  a_read_return_follows_issue: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACCESS) && !cmd_r |=> rd_pend_r)
    else $error("read issued without a pending return");

endmodule
`default_nettype wire

// File: sim/access_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// access_result_checker: predicts and checks region-decoded store accesses
// Watches the configuration port and both streams of the mask-match region
// memory access unit. Each accepted access is decoded against its own copy of
// the region registers and the byte store; each accepted result is compared
// with the oldest predicted reply.
// ----------------------------------------------------------------------------
module access_result_checker (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_tvalid,
  input  wire                             in_tready,
  input  wire  [87:0]                     in_tdata,
  input  wire  [1:0]                      in_tuser,
  input  wire                             out_tvalid,
  input  wire                             out_tready,
  input  wire  [63:0]                     out_tdata,
  input  wire  [1:0]                      out_tuser,
  input  wire                             cfg_we,
  input  wire  [mmrma_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire  [mmrma_pkg::DESC_W-1:0]    cfg_wdata,
  output logic [31:0]                     error_count,
  output logic [31:0]                     awaited_count
);
  import mmrma_pkg::*;

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [1:0]        status;
  } access_reply_t;

  logic [7:0]          byte_store [STORE_BYTES];
  logic [COUNT_W-1:0]  region_count;
  logic [DESC_W-1:0]   region_desc [REGION_REGS];
  logic [CFG_IDX_W-1:0] cfg_off;
  access_reply_t       predicted_replies [$];
  access_reply_t       want;

  function automatic access_reply_t serve_access(
    input logic              is_write,
    input logic [ADDR_W-1:0] addr,
    input logic [BC_W-1:0]   count,
    input logic              space,
    input logic [DATA_W-1:0] wdata
  );
    access_reply_t      reply;
    logic [ADDR_W-1:0]  mask;
    logic [ADDR_W-1:0]  match;
    logic [1:0]         rtype;
    logic [LOCAL_W-1:0] local_idx;
    logic [STORE_AW-1:0] idx;
    logic [BC_W-1:0]    nbytes;
    logic               hit;
    int                 active;
    int                 r;
    int                 i;
    reply.data   = '0;
    reply.status = ST_NOREGION;
    hit          = 1'b0;
    nbytes       = (count > MAX_BYTES) ? MAX_BYTES : count;
    active       = int'(region_count);
    if (active > MAX_REGIONS) active = MAX_REGIONS;
    if (active > REGION_REGS) active = REGION_REGS;
    for (r = 0; r < active; r++) begin
      if (!hit) begin
        mask  = region_desc[r][19:0];
        match = region_desc[r][39:20];
        rtype = region_desc[r][41:40];
        if ((addr & mask) == match && (rtype == {1'b0, space} || rtype == RT_BOTH)) begin
          hit = 1'b1;
          if (is_write && !region_desc[r][42]) begin
            reply.status = ST_REFUSED;
          end else if (region_desc[r][43]) begin
            reply.status = ST_DEVICE;
          end else begin
            reply.status = ST_SERVED;
            local_idx = {1'b0, addr & ~mask} + {5'b0, region_desc[r][59:44]};
            for (i = 0; i < nbytes; i++) begin
              idx = local_idx[STORE_AW-1:0] + STORE_AW'(i);
              if (is_write) byte_store[idx] = wdata[8*i +: 8];
              else reply.data[8*i +: 8] = byte_store[idx];
            end
            if (is_write) reply.data = wdata;
          end
        end
      end
    end
    return reply;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < STORE_BYTES; j++) byte_store[j] = 8'h00;
      for (int j = 0; j < REGION_REGS; j++) region_desc[j] = '0;
      region_count = '0;
      predicted_replies.delete();
      error_count   = 0;
      awaited_count = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_REGION_COUNT) begin
          region_count = cfg_wdata[COUNT_W-1:0];
        end else if (cfg_index >= CFG_REGION_0 && cfg_index <= CFG_REGION_LAST) begin
          cfg_off = cfg_index - CFG_REGION_0;
          region_desc[cfg_off[SLOT_W-1:0]] = cfg_wdata;
        end
      end
      if (out_tvalid && out_tready) begin
        if (predicted_replies.size() == 0) begin
          if (error_count < REPORT_LIMIT)
            $display("unexpected result: data %h status %0d", out_tdata, out_tuser);
          error_count = error_count + 1;
        end else begin
          want = predicted_replies.pop_front();
          if (out_tdata !== want.data || out_tuser !== want.status) begin
            if (error_count < REPORT_LIMIT)
              $display("result mismatch: expected data %h status %0d, got data %h status %0d",
                       want.data, want.status, out_tdata, out_tuser);
            error_count = error_count + 1;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        predicted_replies.push_back(serve_access(in_tuser[0],
                                                 {in_tdata[3:0], in_tdata[19:4]},
                                                 in_tdata[23:20], in_tuser[1],
                                                 in_tdata[87:24]));
      end
      awaited_count = predicted_replies.size();
    end
  end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the mask-match region memory access unit
// Drives directed accesses over hand-built region maps, then random accesses
// steered into randomly configured regions, with random gaps and stalls on
// both streams and one long output hold-off. A separate checker predicts and
// compares every result.
// ----------------------------------------------------------------------------
module testbench;
  import mmrma_pkg::*;

  localparam int  CYCLE_LIMIT   = 1000000;
  localparam int  SETTLE_CYCLES = 16;
  localparam int  HOLD_CYCLES   = 400;
  localparam int  RANDOM_PHASES = 6;
  localparam int  PHASE_ITEMS   = 100;
  localparam logic CMD_READ   = 1'b0;
  localparam logic CMD_WRITE  = 1'b1;
  localparam logic SPACE_DATA = 1'b0;
  localparam logic SPACE_CODE = 1'b1;
  localparam logic [1:0] RT_NONE = 2'd3;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [87:0]          in_tdata;
  logic [1:0]           in_tuser;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [63:0]          out_tdata;
  logic [1:0]           out_tuser;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DESC_W-1:0]    cfg_wdata;
  logic [31:0]          error_count;
  logic [31:0]          awaited_count;

  logic [DESC_W-1:0]    phase_desc [REGION_REGS];
  logic [ADDR_W-1:0]    window_base;
  logic                 squeeze;
  int                   send_burst_left;
  int                   recv_burst_left;
  int                   cycle_count;

  mask_match_region_memory_access_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  access_result_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .error_count  (error_count),
    .awaited_count(awaited_count)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic logic [DESC_W-1:0] make_region(
    input logic [ADDR_W-1:0] mask,
    input logic [ADDR_W-1:0] match,
    input logic [1:0]        rtype,
    input logic              writable,
    input logic              device,
    input logic [BASE_W-1:0] base
  );
    return {base, device, writable, rtype, match, mask};
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DESC_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_region(input int slot, input logic [DESC_W-1:0] desc);
    write_reg(CFG_REGION_0 + CFG_IDX_W'(slot), desc);
    phase_desc[slot] = desc;
  endtask

  // present one transaction after a random gap and hold it until accepted
  task automatic send_access(
    input logic              cmd,
    input logic [3:0]        seg,
    input logic [15:0]       off,
    input logic [BC_W-1:0]   cnt,
    input logic              spc,
    input logic [DATA_W-1:0] wdata
  );
    int gap;
    if (send_burst_left > 0) begin
      gap = 0;
      send_burst_left--;
    end else begin
      gap = $urandom_range(0, 18);
      if ($urandom_range(0, 39) == 0) send_burst_left = $urandom_range(20, 40);
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {wdata, cnt, off, seg};
    in_tuser  <= {spc, cmd};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic send_random_access();
    logic [31:0]       r32;
    logic [ADDR_W-1:0] mask;
    logic [ADDR_W-1:0] match;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] low_part;
    logic [BC_W-1:0]   cnt;
    int                slot;
    slot     = $urandom_range(0, REGION_REGS - 1);
    mask     = phase_desc[slot][19:0];
    match    = phase_desc[slot][39:20];
    low_part = window_base + ADDR_W'($urandom_range(0, 47));
    addr     = (match & mask) | (low_part & ~mask);
    if ($urandom_range(0, 5) == 0) begin
      r32  = $urandom;
      addr = r32[ADDR_W-1:0];
    end
    if ($urandom_range(0, 9) == 0) cnt = BC_W'($urandom_range(0, 15));
    else cnt = BC_W'($urandom_range(1, 8));
    r32 = $urandom;
    send_access(r32[0], addr[19:16], addr[15:0], cnt, r32[1], {$urandom, $urandom});
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (awaited_count != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic randomize_regions(input logic extremes);
    logic [31:0]       r32;
    logic [ADDR_W-1:0] mask;
    logic [ADDR_W-1:0] match;
    int                k;
    int                slot;
    for (slot = 0; slot < REGION_REGS; slot++) begin
      k    = $urandom_range(0, 8);
      mask = 20'hFFFFF << (20 - k);
      if ($urandom_range(0, 7) == 0) begin
        r32  = $urandom;
        mask = r32[ADDR_W-1:0];
      end
      r32   = $urandom;
      match = r32[ADDR_W-1:0] & mask;
      if ($urandom_range(0, 9) == 0) begin
        r32   = $urandom;
        match = r32[ADDR_W-1:0];
      end
      r32 = $urandom;
      set_region(slot, make_region(mask, match, r32[1:0], r32[2],
                                   $urandom_range(0, 4) == 0, r32[31:16]));
    end
    if (extremes) begin
      set_region(0, make_region(20'hFFFFF, match, RT_BOTH, 1'b1, 1'b0, 16'hFFFF));
      set_region(REGION_REGS - 1, {DESC_W{1'b1}});
      write_reg(CFG_REGION_COUNT, DESC_W'({COUNT_W{1'b1}}));
    end else if ($urandom_range(0, 4) == 0) begin
      write_reg(CFG_REGION_COUNT, DESC_W'($urandom_range(0, 7)));
    end else begin
      write_reg(CFG_REGION_COUNT, DESC_W'(MAX_REGIONS));
    end
    r32 = $urandom;
    window_base = r32[ADDR_W-1:0];
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int stall;
    out_tready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (squeeze) begin
        squeeze = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (recv_burst_left > 0) begin
        stall = 0;
        recv_burst_left--;
      end else begin
        stall = $urandom_range(0, 18);
        if ($urandom_range(0, 39) == 0) recv_burst_left = $urandom_range(20, 40);
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    rst_n           = 1'b0;
    in_tvalid       = 1'b0;
    in_tdata        = '0;
    in_tuser        = '0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_wdata       = '0;
    squeeze         = 1'b0;
    send_burst_left = 0;
    recv_burst_left = 0;
    window_base     = '0;
    for (int j = 0; j < REGION_REGS; j++) phase_desc[j] = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // reset map: nothing decodes
    send_access(CMD_WRITE, 4'h0, 16'h0000, 4'd8, SPACE_DATA, {DATA_W{1'b1}});
    send_access(CMD_READ, 4'hF, 16'hFFFF, 4'd8, SPACE_CODE, '0);
    drain();

    // one region per kind, each decoded on the segment number
    set_region(0, make_region(20'hF0000, 20'h10000, RT_DATA, 1'b1, 1'b0, 16'h0000));
    set_region(1, make_region(20'hF0000, 20'h20000, RT_CODE, 1'b0, 1'b0, 16'h1000));
    set_region(2, make_region(20'hF0000, 20'h30000, RT_BOTH, 1'b1, 1'b1, 16'h2000));
    set_region(3, make_region(20'hF0000, 20'h40000, RT_BOTH, 1'b0, 1'b1, 16'h3000));
    write_reg(CFG_REGION_COUNT, DESC_W'(MAX_REGIONS));
    send_access(CMD_WRITE, 4'h1, 16'hFFFF, 4'd8, SPACE_DATA, 64'h0123_4567_89AB_CDEF);
    send_access(CMD_READ,  4'h1, 16'hFFFF, 4'd8, SPACE_DATA, '0);
    send_access(CMD_READ,  4'h1, 16'hFFFC, 4'd3, SPACE_DATA, '0);
    send_access(CMD_WRITE, 4'h1, 16'h0000, 4'd0, SPACE_DATA, 64'hDEAD_BEEF_0000_0001);
    send_access(CMD_READ,  4'h1, 16'h0000, 4'd0, SPACE_DATA, '0);
    send_access(CMD_WRITE, 4'h1, 16'h0100, 4'd15, SPACE_DATA, {DATA_W{1'b1}});
    send_access(CMD_READ,  4'h1, 16'h00FE, 4'd12, SPACE_DATA, '0);
    send_access(CMD_READ,  4'h1, 16'h0100, 4'd4, SPACE_CODE, '0);
    send_access(CMD_READ,  4'h2, 16'h0010, 4'd4, SPACE_CODE, '0);
    send_access(CMD_WRITE, 4'h2, 16'h0010, 4'd4, SPACE_CODE, 64'h1111_2222_3333_4444);
    send_access(CMD_READ,  4'h2, 16'h0010, 4'd4, SPACE_DATA, '0);
    send_access(CMD_READ,  4'h3, 16'h0020, 4'd1, SPACE_DATA, '0);
    send_access(CMD_WRITE, 4'h3, 16'h0020, 4'd1, SPACE_CODE, 64'h55);
    send_access(CMD_WRITE, 4'h4, 16'h0030, 4'd2, SPACE_DATA, 64'hAAAA);
    send_access(CMD_READ,  4'h4, 16'h0030, 4'd2, SPACE_CODE, '0);
    send_access(CMD_READ,  4'hF, 16'h0000, 4'd8, SPACE_DATA, '0);
    drain();

    // oversized count saturates, a short count hides the later regions
    write_reg(CFG_REGION_COUNT, DESC_W'({COUNT_W{1'b1}}));
    send_access(CMD_READ, 4'h4, 16'h0030, 4'd2, SPACE_DATA, '0);
    drain();
    write_reg(CFG_REGION_COUNT, DESC_W'(2));
    send_access(CMD_READ, 4'h3, 16'h0020, 4'd1, SPACE_DATA, '0);
    drain();
    for (int j = CFG_REGION_LAST + 1; j < (1 << CFG_IDX_W); j++)
      write_reg(CFG_IDX_W'(j), {DESC_W{1'b1}});
    send_access(CMD_READ, 4'h1, 16'h0100, 4'd8, SPACE_DATA, '0);
    drain();

    // unmatchable type, match outside mask, store overrun, catch-all
    set_region(0, make_region(20'h00000, 20'h00000, RT_NONE, 1'b1, 1'b0, 16'h0000));
    set_region(1, make_region(20'h0000F, 20'h00010, RT_BOTH, 1'b1, 1'b0, 16'h0000));
    set_region(2, make_region(20'hF0000, 20'hF0000, RT_BOTH, 1'b1, 1'b0, 16'hFFFF));
    set_region(3, make_region(20'h00000, 20'h00000, RT_BOTH, 1'b1, 1'b0, 16'h0000));
    write_reg(CFG_REGION_COUNT, DESC_W'(MAX_REGIONS));
    send_access(CMD_READ,  4'h0, 16'h0010, 4'd8, SPACE_DATA, '0);
    send_access(CMD_WRITE, 4'hF, 16'hFFFE, 4'd8, SPACE_CODE, 64'hFEDC_BA98_7654_3210);
    send_access(CMD_READ,  4'h0, 16'hFFFD, 4'd8, SPACE_DATA, '0);
    send_access(CMD_READ,  4'h0, 16'h0000, 4'd5, SPACE_CODE, '0);
    drain();
    write_reg(CFG_REGION_COUNT, '0);
    send_access(CMD_READ, 4'h0, 16'h0000, 4'd8, SPACE_DATA, '0);
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      randomize_regions(p == RANDOM_PHASES - 1);
      if (p == 0) begin
        squeeze         = 1'b1;
        send_burst_left = 60;
      end
      repeat (PHASE_ITEMS) send_random_access();
      drain();
    end

    if (error_count == 0 && awaited_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/mmrma_pkg.sv
src/mmrma_decode.sv
src/mmrma_store.sv
src/mask_match_region_memory_access_unit.sv
sim/access_result_checker.sv
sim/testbench.sv
